// ===== rtl/core/ple_pkg.sv =====
`default_nettype none

package ple_pkg;

	// Fixed field widths of the request and response
	localparam int unsigned PLE_OP_W    = 3;
	localparam int unsigned PLE_VAL_W   = 32;
	localparam int unsigned PLE_POS_W   = 5;
	localparam int unsigned PLE_CNT_W   = 5;
	localparam int unsigned PLE_STAT_W  = 2;

	// Default list capacity
	localparam int unsigned PLE_CAPACITY = 16;

	// Command codes
	typedef enum logic [PLE_OP_W-1:0] {
		OP_INS_HEAD = 3'd0,
		OP_INS_TAIL = 3'd1,
		OP_INS_POS  = 3'd2,
		OP_DEL_HEAD = 3'd3,
		OP_DEL_TAIL = 3'd4,
		OP_DEL_POS  = 3'd5
	} ple_op_t;

	// Response status codes
	typedef enum logic [PLE_STAT_W-1:0] {
		STAT_OK     = 2'd0,
		STAT_EMPTY  = 2'd1,
		STAT_BADPOS = 2'd2,
		STAT_FULL   = 2'd3
	} ple_status_t;

	typedef struct packed {
		logic [PLE_OP_W-1:0]         op;
		logic signed [PLE_VAL_W-1:0] value;
		logic [PLE_POS_W-1:0]        position;
	} ple_req_t;

	typedef struct packed {
		logic signed [PLE_VAL_W-1:0] removed_value;
		logic [PLE_STAT_W-1:0]       status;
		logic [PLE_CNT_W-1:0]        entry_count;
	} ple_rsp_t;

	// Controller states
	typedef enum logic {
		ST_IDLE,
		ST_EXEC
	} ple_state_t;

	// Commands from controller to datapath
	typedef struct packed {
		logic load;   // capture the incoming request
		logic exec;   // apply the held request and write the response register
	} ple_cmd_t;

endpackage

`default_nettype wire

// ===== rtl/core/ple_ctrl.sv =====
`default_nettype none

module ple_ctrl (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          req_valid,
	output      logic          req_stall,
	output      logic          rsp_valid,
	input  wire logic          rsp_stall,
	output      ple_pkg::ple_cmd_t cmd
);
	import ple_pkg::*;

	ple_state_t state_q, state_d;
	logic       rsp_valid_q;

	// State and response-valid registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.exec) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	// Next state and commands
	always_comb begin
		state_d   = state_q;
		cmd       = '0;
		req_stall = 1'b1;
		unique case (state_q)
			ST_IDLE: begin
				req_stall = 1'b0;
				if (req_valid) begin
					cmd.load = 1'b1;
					state_d  = ST_EXEC;
				end
			end
			ST_EXEC: begin
				// execute once the response slot is free or being drained
				if (!rsp_valid_q || !rsp_stall) begin
					cmd.exec = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	assign rsp_valid = rsp_valid_q;

endmodule

`default_nettype wire

// ===== rtl/core/ple_dp.sv =====
`default_nettype none

module ple_dp #(
	parameter int unsigned CAPACITY = ple_pkg::PLE_CAPACITY
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire ple_pkg::ple_cmd_t cmd,
	input  wire ple_pkg::ple_req_t req_data,
	output      ple_pkg::ple_rsp_t rsp_data
);
	import ple_pkg::*;

	localparam int unsigned CW  = $clog2(CAPACITY + 1);
	localparam int unsigned IW  = $clog2(CAPACITY);
	localparam int unsigned FW  = (PLE_POS_W > PLE_CNT_W) ? PLE_POS_W : PLE_CNT_W;
	localparam int unsigned AW  = (CW > FW) ? CW : FW;

	ple_req_t              req_q;
	ple_rsp_t              rsp_q;
	logic [PLE_VAL_W-1:0]  cells_q [CAPACITY];
	logic [CW-1:0]         count_q;

	logic [AW-1:0]         cnt_ext;
	logic [AW-1:0]         at;
	logic [AW-1:0]         new_ext;
	logic [CW-1:0]         count_d;
	logic                  do_ins;
	logic                  do_del;
	ple_status_t           status;
	logic [PLE_VAL_W-1:0]  removed;

	assign cnt_ext = AW'(count_q);

	// Request holding register
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			req_q <= req_data;
		end
	end

	// Decode: target position, checks and status
	always_comb begin
		at     = '0;
		do_ins = 1'b0;
		do_del = 1'b0;
		status = STAT_OK;
		unique case (req_q.op)
			OP_INS_HEAD: at = '0;
			OP_INS_TAIL: at = cnt_ext;
			OP_INS_POS:  at = AW'(req_q.position);
			OP_DEL_HEAD: at = '0;
			OP_DEL_TAIL: at = (count_q == '0) ? '0 : cnt_ext - AW'(1);
			OP_DEL_POS:  at = AW'(req_q.position);
			default:     at = '0;
		endcase
		unique case (req_q.op)
			OP_INS_HEAD, OP_INS_TAIL, OP_INS_POS: begin
				if (at > cnt_ext) begin
					status = STAT_BADPOS;
				end else if (cnt_ext >= AW'(CAPACITY)) begin
					status = STAT_FULL;
				end else begin
					do_ins = 1'b1;
				end
			end
			OP_DEL_HEAD, OP_DEL_TAIL, OP_DEL_POS: begin
				if (count_q == '0) begin
					status = STAT_EMPTY;
				end else if (req_q.op == OP_DEL_POS && at >= cnt_ext) begin
					status = STAT_BADPOS;
				end else begin
					do_del = 1'b1;
				end
			end
			default: begin
				status = STAT_OK;
			end
		endcase
	end

	// Value leaving the list on a delete
	assign removed = do_del ? cells_q[at[IW-1:0]] : '0;

	// Count update
	always_comb begin
		count_d = count_q;
		if (do_ins) begin
			count_d = count_q + CW'(1);
		end else if (do_del) begin
			count_d = count_q - CW'(1);
		end
	end

	assign new_ext = AW'(count_d);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (cmd.exec) begin
			count_q <= count_d;
		end
	end

	// Row of cells: each one takes its left or right neighbor to open or close a gap
	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		localparam logic [AW-1:0] IDX = AW'(i);
		logic [PLE_VAL_W-1:0] prev_v;
		logic [PLE_VAL_W-1:0] next_v;
		logic [PLE_VAL_W-1:0] cell_d;

		if (i == 0) begin : g_first
			assign prev_v = cells_q[i];
		end else begin : g_prev
			assign prev_v = cells_q[i-1];
		end

		if (i == CAPACITY - 1) begin : g_last
			assign next_v = cells_q[i];
		end else begin : g_next
			assign next_v = cells_q[i+1];
		end

		always_comb begin
			cell_d = cells_q[i];
			if (do_ins) begin
				if (IDX == at) begin
					cell_d = req_q.value;
				end else if (IDX > at) begin
					cell_d = prev_v;
				end
			end else if (do_del) begin
				if (IDX >= at) begin
					cell_d = next_v;
				end
			end
		end

		always_ff @(posedge clk) begin
			if (cmd.exec) begin
				cells_q[i] <= cell_d;
			end
		end
	end

	// Response register
	always_ff @(posedge clk) begin
		if (cmd.exec) begin
			rsp_q.removed_value <= removed;
			rsp_q.status        <= status;
			rsp_q.entry_count   <= new_ext[PLE_CNT_W-1:0];
		end
	end

	assign rsp_data = rsp_q;

endmodule

`default_nettype wire

// ===== rtl/core/positional_list_engine.sv =====
// Positional list engine: an ordered list of up to CAPACITY signed 32-bit values.
// Request channel (req_valid / req_stall / req_data): op selects insert at head,
// tail or position, or delete from head, tail or position; value is the entry
// to insert; position is the zero-based slot for the positional commands.
// Response channel (rsp_valid / rsp_stall / rsp_data): one response per request
// with the removed value (zero unless a delete succeeded), a status
// (ok, empty, bad position, full) and the entry count after the command.
// A request is taken when valid is high and stall is low at a clock edge.
// An accepted request is captured in the request register; the cell row then
// shifts to open or close the gap and the response register is written, once
// the response slot is free. The next request is accepted only after that
// execution, so one request is in flight at a time.
// When the receiver stalls, the response stays in its register and a new
// request may still be accepted; it then waits until the response is taken.
// Reset clears the count and the controller; the list starts empty.
`default_nettype none

module positional_list_engine #(
	parameter int unsigned CAPACITY = ple_pkg::PLE_CAPACITY
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              req_valid,
	output      logic              req_stall,
	input  wire ple_pkg::ple_req_t req_data,
	output      logic              rsp_valid,
	input  wire logic              rsp_stall,
	output      ple_pkg::ple_rsp_t rsp_data
);
	import ple_pkg::*;

	ple_cmd_t cmd;

	ple_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.cmd       (cmd)
	);

	ple_dp #(
		.CAPACITY (CAPACITY)
	) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.req_data (req_data),
		.rsp_data (rsp_data)
	);

	// One request in flight: an accepted request blocks the next one
	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		(req_valid && !req_stall) |=> req_stall)
		else $error("request accepted while another is in flight");

	// A waiting response is never overwritten
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.exec |-> !(rsp_valid && rsp_stall))
		else $error("response overwritten while stalled");

	// Execution always produces a response
	a_exec_rsp: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.exec |=> rsp_valid)
		else $error("execution without response");

	// An empty-list delete removes nothing and leaves the count at zero
	a_empty_rsp: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && rsp_data.status == STAT_EMPTY) |->
		(rsp_data.entry_count == '0 && rsp_data.removed_value == '0))
		else $error("empty status with nonzero count or value");

endmodule

`default_nettype wire
